/* rtl/dmwt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwt_pkg: shared types and constants of the weight table
// Transaction structs, command and status codes, result helpers.
// ----------------------------------------------------------------------------
package dmwt_pkg;

  localparam int PART_W      = 16;
  localparam int PORT_PARTS  = 8;
  localparam int WEIGHT_W    = 32;
  localparam int OUT_IDX_W   = 6;
  localparam int STATUS_W    = 3;
  localparam int CMD_W       = 2;
  localparam int CFG_W       = 4;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_MAX_PARTS   = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DRAINED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  typedef logic [PORT_PARTS-1:0][PART_W-1:0] parts_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [PART_W-1:0]   part_0;
    logic [PART_W-1:0]   part_1;
    logic [PART_W-1:0]   part_2;
    logic [PART_W-1:0]   part_3;
    logic [PART_W-1:0]   part_4;
    logic [PART_W-1:0]   part_5;
    logic [PART_W-1:0]   part_6;
    logic [PART_W-1:0]   part_7;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [PART_W-1:0]    out_part_0;
    logic [PART_W-1:0]    out_part_1;
    logic [PART_W-1:0]    out_part_2;
    logic [PART_W-1:0]    out_part_3;
    logic [PART_W-1:0]    out_part_4;
    logic [PART_W-1:0]    out_part_5;
    logic [PART_W-1:0]    out_part_6;
    logic [PART_W-1:0]    out_part_7;
    logic [WEIGHT_W-1:0]  weight_sum;
    logic                 last_result;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic cmp;
    logic shift;
    logic load;
    logic wset;
  } cell_ctl_t;

  function automatic parts_t item_parts(input in_item_t it);
    return {it.part_7, it.part_6, it.part_5, it.part_4,
            it.part_3, it.part_2, it.part_1, it.part_0};
  endfunction

  function automatic out_item_t make_result(input logic [STATUS_W-1:0] st,
                                            input logic [OUT_IDX_W-1:0] idx,
                                            input parts_t p,
                                            input logic [WEIGHT_W-1:0] w,
                                            input logic last);
    out_item_t r;
    r.status      = st;
    r.entry_index = idx;
    r.out_part_0  = p[0];
    r.out_part_1  = p[1];
    r.out_part_2  = p[2];
    r.out_part_3  = p[3];
    r.out_part_4  = p[4];
    r.out_part_5  = p[5];
    r.out_part_6  = p[6];
    r.out_part_7  = p[7];
    r.weight_sum  = w;
    r.last_result = last;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/dmwt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwt_cell: one table entry
// Holds a key and a weight sum, compares against the broadcast key and
// takes its neighbor's contents when the chain rotates.
// ----------------------------------------------------------------------------
module dmwt_cell #(
  parameter int MAX_PARTS = dmwt_pkg::DEF_MAX_PARTS
) (
  input  wire                                          clk,
  input  dmwt_pkg::cell_ctl_t                          ctl,
  input  wire [MAX_PARTS-1:0]                          part_mask,
  input  wire [MAX_PARTS-1:0][dmwt_pkg::PART_W-1:0]    q_key,
  input  wire [dmwt_pkg::WEIGHT_W-1:0]                 q_weight,
  input  wire [MAX_PARTS-1:0][dmwt_pkg::PART_W-1:0]    nb_key,
  input  wire [dmwt_pkg::WEIGHT_W-1:0]                 nb_weight,
  input  wire [dmwt_pkg::WEIGHT_W-1:0]                 upd_weight,
  output logic [MAX_PARTS-1:0][dmwt_pkg::PART_W-1:0]   key,
  output logic [dmwt_pkg::WEIGHT_W-1:0]                weight,
  output logic                                         match
);
  import dmwt_pkg::*;

  logic eq;

  always_comb begin
    eq = 1'b1;
    for (int j = 0; j < MAX_PARTS; j++) begin
      if (part_mask[j] && (key[j] != q_key[j])) begin
        eq = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key    <= q_key;
      weight <= q_weight;
    end else if (ctl.shift) begin
      key    <= nb_key;
      weight <= nb_weight;
    end else if (ctl.wset) begin
      weight <= upd_weight;
    end
    if (ctl.cmp) begin
      match <= ctl.valid & eq;
    end
  end

endmodule
`default_nettype wire

/* rtl/duplicate_merging_weight_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// duplicate_merging_weight_table: group-by-key weight sum table
// Chain of entry cells with a small sequencer for add, drain and clear.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a clock edge with start high and busy
//   low. Every result appears on result for one cycle with result_valid
//   high; the receiver cannot stall it, so results are never held back.
//   cfg_we/cfg_wdata write parts_in_use; write it only while idle.
// Command sequencing:
//   add   : result after the compare, pick, select and update states, busy
//           throughout them; the next transaction is taken at the edge that ends
//           the result cycle (compare in every cell, first-match pick, weight
//           select, saturating add and write-back, one step per state).
//   drain : one result per cycle, one per stored entry, the first one
//           registered in the drain state; the entry chain rotates by one
//           per cycle and is back in order after the last entry.
//   clear, drain of an empty table: one result in the next cycle, no busy.
//   command 3 is taken and dropped without a result.
// Reset:
//   rst empties the table and sets parts_in_use to 8; no clearing pass.
// ----------------------------------------------------------------------------
module duplicate_merging_weight_table #(
  parameter int MAX_ENTRIES = dmwt_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_PARTS   = dmwt_pkg::DEF_MAX_PARTS
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  dmwt_pkg::in_item_t            item,
  input  wire                           cfg_we,
  input  wire [dmwt_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          result_valid,
  output dmwt_pkg::out_item_t           result
);
  import dmwt_pkg::*;

  localparam int IDXW = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_SEL   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0]             state;
  logic [CNTW-1:0]        count;
  logic [CFG_W-1:0]       parts_in_use;
  logic [IDXW-1:0]        drain_cnt;

  logic [CFG_W-1:0]       act_n;
  logic [MAX_PARTS-1:0]   part_mask;
  parts_t                 mask8;

  parts_t                 q_parts;
  logic [WEIGHT_W-1:0]    q_weight;
  logic [MAX_ENTRIES-1:0] first;
  logic                   hit;
  logic [IDXW-1:0]        hit_idx;
  logic [WEIGHT_W-1:0]    sel_weight;

  logic [MAX_PARTS-1:0][PART_W-1:0] cell_key [MAX_ENTRIES];
  logic [WEIGHT_W-1:0]              cell_weight [MAX_ENTRIES];
  logic [MAX_PARTS-1:0][PART_W-1:0] nb_key [MAX_ENTRIES];
  logic [WEIGHT_W-1:0]              nb_weight [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]           match_v;
  logic [MAX_ENTRIES-1:0]           valid_v;
  cell_ctl_t                        ctl [MAX_ENTRIES];

  logic                   accept;
  logic                   full;
  logic [CNTW-1:0]        count_m1;
  logic                   drain_last;
  logic [WEIGHT_W:0]      sum_wide;
  logic [WEIGHT_W-1:0]    upd_weight;
  logic [IDXW-1:0]        enc_idx;
  logic [WEIGHT_W-1:0]    enc_weight;

  assign busy     = (state != S_IDLE);
  assign accept   = start & ~busy;
  assign full     = (count == CNTW'(MAX_ENTRIES));
  assign count_m1 = CNTW'(count - 1'b1);
  assign drain_last = (CNTW'(drain_cnt) == count_m1);

  // Clamp the part count to 1..MAX_PARTS.
  always_comb begin
    if (parts_in_use == '0) begin
      act_n = CFG_W'(1);
    end else if (parts_in_use > CFG_W'(MAX_PARTS)) begin
      act_n = CFG_W'(MAX_PARTS);
    end else begin
      act_n = parts_in_use;
    end
    for (int j = 0; j < PORT_PARTS; j++) begin
      mask8[j] = (CFG_W'(j) < act_n) ? {PART_W{1'b1}} : '0;
    end
    for (int j = 0; j < MAX_PARTS; j++) begin
      part_mask[j] = (CFG_W'(j) < act_n);
    end
  end

  assign sum_wide   = {1'b0, sel_weight} + {1'b0, q_weight};
  assign upd_weight = sum_wide[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum_wide[WEIGHT_W-1:0];

  always_comb begin
    enc_idx    = '0;
    enc_weight = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (first[i]) begin
        enc_idx    = enc_idx | IDXW'(i);
        enc_weight = enc_weight | cell_weight[i];
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      assign valid_v[gi] = (CNTW'(gi) < count);
      if (gi == MAX_ENTRIES - 1) begin : g_tail
        assign nb_key[gi]    = cell_key[0];
        assign nb_weight[gi] = cell_weight[0];
      end else begin : g_mid
        assign nb_key[gi]    = (CNTW'(gi) == count_m1) ? cell_key[0] : cell_key[gi+1];
        assign nb_weight[gi] = (CNTW'(gi) == count_m1) ? cell_weight[0]
                                                       : cell_weight[gi+1];
      end
      assign ctl[gi].valid = valid_v[gi];
      assign ctl[gi].cmp   = (state == S_CMP);
      assign ctl[gi].shift = (state == S_DRAIN) & valid_v[gi];
      assign ctl[gi].load  = (state == S_UPD) & ~hit & ~full & (CNTW'(gi) == count);
      assign ctl[gi].wset  = (state == S_UPD) & hit & first[gi];

      dmwt_cell #(
        .MAX_PARTS (MAX_PARTS)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl[gi]),
        .part_mask  (part_mask),
        .q_key      (q_parts[MAX_PARTS-1:0]),
        .q_weight   (q_weight),
        .nb_key     (nb_key[gi]),
        .nb_weight  (nb_weight[gi]),
        .upd_weight (upd_weight),
        .key        (cell_key[gi]),
        .weight     (cell_weight[gi]),
        .match      (match_v[gi])
      );
    end
  endgenerate

  // Transaction payload and search pipeline registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_parts  <= item_parts(item) & mask8;
      q_weight <= item.weight;
    end
    if (state == S_PICK) begin
      first <= match_v & (~match_v + MAX_ENTRIES'(1));
      hit   <= |match_v;
    end
    if (state == S_SEL) begin
      hit_idx    <= enc_idx;
      sel_weight <= enc_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      parts_in_use <= CFG_RESET;
      drain_cnt    <= '0;
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        parts_in_use <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.command)
              CMD_ADD: begin
                state <= S_CMP;
              end
              CMD_DRAIN: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                  result       <= make_result(ST_EMPTY, '0, '0, '0, 1'b1);
                end else begin
                  state     <= S_DRAIN;
                  drain_cnt <= '0;
                end
              end
              CMD_CLEAR: begin
                count        <= '0;
                result_valid <= 1'b1;
                result       <= make_result(ST_CLEARED, '0, '0, '0, 1'b1);
              end
              default: begin
              end
            endcase
          end
        end
        S_CMP: begin
          state <= S_PICK;
        end
        S_PICK: begin
          state <= S_SEL;
        end
        S_SEL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state        <= S_IDLE;
          result_valid <= 1'b1;
          if (hit) begin
            result <= make_result(ST_MERGED, OUT_IDX_W'(hit_idx), q_parts,
                                  upd_weight, 1'b1);
          end else if (full) begin
            result <= make_result(ST_DROPPED, '0, q_parts, q_weight, 1'b1);
          end else begin
            result <= make_result(ST_NEW, OUT_IDX_W'(count), q_parts, q_weight, 1'b1);
            count  <= CNTW'(count + 1'b1);
          end
        end
        S_DRAIN: begin
          result_valid <= 1'b1;
          result       <= make_result(ST_DRAINED, OUT_IDX_W'(drain_cnt),
                                      parts_t'(cell_key[0]) & mask8,
                                      cell_weight[0], drain_last);
          drain_cnt    <= IDXW'(drain_cnt + 1'b1);
          if (drain_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/dmwt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwt_checker: port-level checks of the weight table
// Result ordering and field rules seen at the top level's ports.
// ----------------------------------------------------------------------------
module dmwt_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  start,
  input wire                  busy,
  input dmwt_pkg::in_item_t   item,
  input wire                  result_valid,
  input dmwt_pkg::out_item_t  result
);
  import dmwt_pkg::*;

  logic take;
  assign take = start & ~busy & ~rst;

  a_clear_reply: assert property (@(posedge clk) disable iff (rst)
    (take && item.command == CMD_CLEAR) |=>
      (result_valid && result.status == ST_CLEARED && result.last_result))
    else $error("clear transaction without cleared result");

  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    (take && item.command == CMD_ADD) |=> (busy && !result_valid))
    else $error("add transaction did not hold busy");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_DRAINED) |-> result.last_result)
    else $error("single result not marked last");

  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == ST_EMPTY || result.status == ST_CLEARED ||
                      result.status == ST_DROPPED)) |-> (result.entry_index == '0))
    else $error("nonzero index on status without slot");

endmodule

bind duplicate_merging_weight_table dmwt_checker u_dmwt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for duplicate_merging_weight_table
// Drives add, drain, clear and unused commands through the start/busy
// handshake with random gaps, rewrites parts_in_use between phases, and
// compares every result strobe field by field against an in-bench model of
// the keyed weight table (first-match merge, saturating sums, append, drop
// when full, ordered drain).
// ----------------------------------------------------------------------------
module testbench;
  import dmwt_pkg::*;

  localparam int MAX_ENTRIES   = DEF_MAX_ENTRIES;
  localparam int MAX_PARTS     = DEF_MAX_PARTS;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int NUM_SEGS      = 10;
  localparam int SEG_ITEMS     = 12;
  localparam int FILL_SEG      = 5;
  localparam int POOL_KEYS     = 5;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]    command;
    parts_t              key;
    logic [WEIGHT_W-1:0] weight;
    bit                  typed;
    out_item_t           want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  in_item_t            cmd_word;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                result_valid;
  out_item_t           report;

  parts_t              slot_key [MAX_ENTRIES];
  logic [WEIGHT_W-1:0] slot_sum [MAX_ENTRIES];
  int                  slot_count = 0;
  logic [CFG_W-1:0]    parts_cfg  = CFG_RESET;

  out_item_t           pending_reports [$];
  dir_row_t            dir_rows [$];
  logic [CFG_W-1:0]    seg_cfg [NUM_SEGS];
  bit                  no_gaps = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  duplicate_merging_weight_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_PARTS  (MAX_PARTS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (cmd_word),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .result_valid(result_valid),
    .result      (report)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic parts_t clip_key(input parts_t k, input int n);
    parts_t c;
    c = k;
    for (int j = 0; j < MAX_PARTS; j++) begin
      if (j >= n) c[j] = '0;
    end
    return c;
  endfunction

  function automatic out_item_t table_report(input logic [STATUS_W-1:0] st,
                                             input logic [OUT_IDX_W-1:0] idx,
                                             input parts_t p,
                                             input logic [WEIGHT_W-1:0] w,
                                             input logic last);
    out_item_t r;
    r = '{status: st, entry_index: idx, out_part_0: p[0], out_part_1: p[1],
          out_part_2: p[2], out_part_3: p[3], out_part_4: p[4],
          out_part_5: p[5], out_part_6: p[6], out_part_7: p[7],
          weight_sum: w, last_result: last};
    return r;
  endfunction

  function automatic in_item_t build_item(input logic [CMD_W-1:0] cmd, input parts_t k,
                                          input logic [WEIGHT_W-1:0] w);
    in_item_t it;
    it.command = cmd;
    it.part_0  = k[0];
    it.part_1  = k[1];
    it.part_2  = k[2];
    it.part_3  = k[3];
    it.part_4  = k[4];
    it.part_5  = k[5];
    it.part_6  = k[6];
    it.part_7  = k[7];
    it.weight  = w;
    return it;
  endfunction

  function automatic parts_t rand_key();
    parts_t k;
    for (int j = 0; j < MAX_PARTS; j++) begin
      case ($urandom_range(0, 5))
        0: k[j] = '0;
        1: k[j] = '1;
        default: k[j] = 16'($urandom);
      endcase
    end
    return k;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'hF000_0000 | $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic dir_row_t mk_row(input logic [CMD_W-1:0] cmd, input parts_t k,
                                      input logic [WEIGHT_W-1:0] w);
    dir_row_t r;
    r.command = cmd;
    r.key     = k;
    r.weight  = w;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic dir_row_t mk_checked(input logic [CMD_W-1:0] cmd, input parts_t k,
                                          input logic [WEIGHT_W-1:0] w,
                                          input logic [STATUS_W-1:0] st,
                                          input logic [OUT_IDX_W-1:0] idx,
                                          input logic [WEIGHT_W-1:0] wsum);
    dir_row_t r;
    r       = mk_row(cmd, k, w);
    r.typed = 1'b1;
    r.want  = table_report(st, idx, k, wsum, 1'b1);
    return r;
  endfunction

  function automatic void predict_table_step(input in_item_t it);
    parts_t     key;
    int         n;
    int         hit;
    logic [32:0] total;
    n   = (parts_cfg == 0) ? 1 : ((parts_cfg > MAX_PARTS) ? MAX_PARTS : int'(parts_cfg));
    key = clip_key({it.part_7, it.part_6, it.part_5, it.part_4,
                    it.part_3, it.part_2, it.part_1, it.part_0}, n);
    hit = -1;
    case (it.command)
      CMD_ADD: begin
        for (int i = 0; i < slot_count && hit < 0; i++) begin
          if (clip_key(slot_key[i], n) == key) hit = i;
        end
        if (hit >= 0) begin
          total = {1'b0, slot_sum[hit]} + {1'b0, it.weight};
          slot_sum[hit] = total[32] ? '1 : total[31:0];
          pending_reports.push_back(table_report(ST_MERGED, 6'(hit),
                                                 clip_key(slot_key[hit], n),
                                                 slot_sum[hit], 1'b1));
        end else if (slot_count >= MAX_ENTRIES) begin
          pending_reports.push_back(table_report(ST_DROPPED, '0, key, it.weight, 1'b1));
        end else begin
          slot_key[slot_count] = key;
          slot_sum[slot_count] = it.weight;
          pending_reports.push_back(table_report(ST_NEW, 6'(slot_count), key,
                                                 it.weight, 1'b1));
          slot_count++;
        end
      end
      CMD_DRAIN: begin
        if (slot_count == 0) begin
          pending_reports.push_back(table_report(ST_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < slot_count; i++) begin
            pending_reports.push_back(table_report(ST_DRAINED, 6'(i),
                                                   clip_key(slot_key[i], n), slot_sum[i],
                                                   i == slot_count - 1));
          end
        end
      end
      CMD_CLEAR: begin
        slot_count = 0;
        pending_reports.push_back(table_report(ST_CLEARED, '0, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    cmd_word <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_table_step(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h actual %h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none actual status %0d",
                 $time, report.status);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 32'(want.status), 32'(report.status));
        check_field("entry_index", 32'(want.entry_index), 32'(report.entry_index));
        check_field("out_part_0", 32'(want.out_part_0), 32'(report.out_part_0));
        check_field("out_part_1", 32'(want.out_part_1), 32'(report.out_part_1));
        check_field("out_part_2", 32'(want.out_part_2), 32'(report.out_part_2));
        check_field("out_part_3", 32'(want.out_part_3), 32'(report.out_part_3));
        check_field("out_part_4", 32'(want.out_part_4), 32'(report.out_part_4));
        check_field("out_part_5", 32'(want.out_part_5), 32'(report.out_part_5));
        check_field("out_part_6", 32'(want.out_part_6), 32'(report.out_part_6));
        check_field("out_part_7", 32'(want.out_part_7), 32'(report.out_part_7));
        check_field("weight_sum", want.weight_sum, report.weight_sum);
        check_field("last_result", 32'(want.last_result), 32'(report.last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    parts_t           k;
    parts_t           pool [POOL_KEYS];
    logic [PART_W-1:0] base;
    int               pick;
    int               p;

    rst       <= 1'b1;
    start     <= 1'b0;
    cmd_word  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    seg_cfg    = '{4'd8, 4'd1, 4'd0, 4'd3, 4'd15, 4'd8, 4'd5, 4'd12, 4'd2, 4'd7};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    dir_rows.push_back(mk_checked(CMD_DRAIN, '0, '0, ST_EMPTY, '0, '0));
    dir_rows.push_back(mk_checked(CMD_CLEAR, '0, '0, ST_CLEARED, '0, '0));
    dir_rows.push_back(mk_checked(CMD_ADD, '0, '0, ST_NEW, 6'd0, '0));
    dir_rows.push_back(mk_checked(CMD_ADD, '1, '1, ST_NEW, 6'd1, '1));
    dir_rows.push_back(mk_checked(CMD_ADD, '1, 32'd1, ST_MERGED, 6'd1, '1));
    dir_rows.push_back(mk_checked(CMD_ADD, '0, 32'h4000_0000, ST_MERGED, 6'd0,
                                  32'h4000_0000));
    dir_rows.push_back(mk_checked(CMD_ADD, '0, 32'hC000_0000, ST_MERGED, 6'd0, '1));
    dir_rows.push_back(mk_checked(CMD_ADD, {16'h0001, 112'h0}, 32'h1234_5678, ST_NEW,
                                  6'd2, 32'h1234_5678));
    dir_rows.push_back(mk_row(CMD_ADD, {112'h0, 16'hFFFF}, 32'd3));
    dir_rows.push_back(mk_row(CMD_ADD, {4{16'h5A5A, 16'hA5A5}}, 32'h8000_0000));
    dir_rows.push_back(mk_row(CMD_DRAIN, '1, '1));
    dir_rows.push_back(mk_row(CMD_NONE, '1, '1));
    dir_rows.push_back(mk_checked(CMD_ADD, {16'h0001, 112'h0}, 32'd1, ST_MERGED, 6'd2,
                                  32'h1234_5679));
    dir_rows.push_back(mk_checked(CMD_CLEAR, '0, '0, ST_CLEARED, '0, '0));
    dir_rows.push_back(mk_checked(CMD_DRAIN, '0, '0, ST_EMPTY, '0, '0));
    dir_rows.push_back(mk_checked(CMD_ADD, '0, '1, ST_NEW, 6'd0, '1));

    foreach (dir_rows[r]) begin
      send_cmd(build_item(dir_rows[r].command, dir_rows[r].key, dir_rows[r].weight));
      if (dir_rows[r].typed) pending_reports[pending_reports.size() - 1] = dir_rows[r].want;
    end

    for (int s = 0; s < NUM_SEGS; s++) begin
      wait_idle();
      cfg_we    <= 1'b1;
      cfg_wdata <= seg_cfg[s];
      @(posedge clk);
      cfg_we    <= 1'b0;
      parts_cfg  = seg_cfg[s];
      no_gaps    = ($urandom_range(0, 2) == 0);

      for (int j = 0; j < POOL_KEYS; j++) pool[j] = rand_key();
      pool[1] = pool[0];
      pool[1][MAX_PARTS-1] = ~pool[0][MAX_PARTS-1];
      pool[2] = pool[0];
      pool[2][1] = pool[0][1] ^ 16'h0001;

      if (s == FILL_SEG) begin
        send_cmd(build_item(CMD_CLEAR, rand_key(), $urandom));
        base = 16'($urandom);
        for (int j = 0; j < MAX_ENTRIES + 3; j++) begin
          k    = rand_key();
          k[0] = base + 16'(j);
          send_cmd(build_item(CMD_ADD, k, rand_weight()));
        end
        send_cmd(build_item(CMD_ADD, slot_key[5], rand_weight()));
        send_cmd(build_item(CMD_DRAIN, rand_key(), $urandom));
      end

      for (int i = 0; i < SEG_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_cmd(build_item(CMD_ADD, pool[$urandom_range(0, POOL_KEYS - 1)],
                              rand_weight()));
        end else if (pick < 60) begin
          k = rand_key();
          if (slot_count > 0) begin
            k = slot_key[$urandom_range(0, slot_count - 1)];
            p = $urandom_range(1, MAX_PARTS);
            for (int j = p; j < MAX_PARTS; j++) k[j] = 16'($urandom);
          end
          send_cmd(build_item(CMD_ADD, k, rand_weight()));
        end else if (pick < 70) begin
          send_cmd(build_item(CMD_ADD, rand_key(), rand_weight()));
        end else if (pick < 82) begin
          send_cmd(build_item(CMD_DRAIN, rand_key(), $urandom));
        end else if (pick < 90) begin
          send_cmd(build_item(CMD_CLEAR, rand_key(), $urandom));
        end else begin
          send_cmd(build_item(CMD_NONE, rand_key(), $urandom));
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dmwt_pkg.sv
rtl/dmwt_cell.sv
rtl/duplicate_merging_weight_table.sv
rtl/dmwt_checker.sv
tb/testbench.sv
